/* hdl/hscsl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hscsl_pkg
// Shared types, constants and the divide-by-1000 helper for the heading,
// speed and climb slew limiter.
// ----------------------------------------------------------------------------
package hscsl_pkg;

  // angle constants, 0.01 degree units
  localparam logic [15:0] FULL_TURN = 16'd36000;
  localparam logic [15:0] HALF_TURN = 16'd18000;

  // largest step is 65535 * 65535 / 1000, which needs 23 bits
  localparam int STEP_W = 23;

  // floor(q / 125) = (q * RECIP_125) >> 36 for q below 2^29
  localparam logic [29:0] RECIP_125 = 30'd549755814;

  // item kind carried on tuser
  typedef enum logic [0:0] {
    CMD_TICK = 1'b0,
    CMD_STOP = 1'b1
  } cmd_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_HEADING_RATE  = 3'd0,
    CFG_ACCELERATION  = 3'd1,
    CFG_CLIMB_RATE    = 3'd2,
    CFG_MAX_SPEED     = 3'd3,
    CFG_MAX_ALTITUDE  = 3'd4,
    CFG_ALT_TOLERANCE = 3'd5
  } cfg_idx_t;

  // load enables of the two pipeline stages ahead of the state update
  typedef struct packed {
    logic s1;
    logic s2;
  } pipe_en_t;

  // truncating divide of a 32-bit product by 1000: shift by 3, then divide by 125
  function automatic logic [STEP_W-1:0] div1000(input logic [31:0] p);
    logic [58:0] prod;
    prod = 59'(p[31:3]) * 59'(RECIP_125);
    return prod[58:36];
  endfunction

endpackage

/* hdl/hscsl_step_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hscsl_step_unit
// Per-tick step size: rate times elapsed milliseconds, registered, then
// divided by 1000 with truncation, registered.
// ----------------------------------------------------------------------------
module hscsl_step_unit import hscsl_pkg::*; (
  input  logic              clk,
  input  pipe_en_t          en,
  input  logic [15:0]       rate,
  input  logic [15:0]       ms,
  output logic [STEP_W-1:0] step
);

  logic [31:0]       prod_r;
  logic [STEP_W-1:0] step_r;

  // rate * dt
  always_ff @(posedge clk) begin
    if (en.s1) begin
      prod_r <= 32'(rate) * 32'(ms);
    end
  end

  // scale milliseconds to seconds
  always_ff @(posedge clk) begin
    if (en.s2) begin
      step_r <= div1000(prod_r);
    end
  end

  assign step = step_r;

endmodule

/* hdl/heading_speed_climb_slew_limiter_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_speed_climb_slew_limiter_top
// Slew-rate limiter for heading, speed and vertical speed of one entity.
// Ticks move the state toward the targets; stop beats zero the motion.
// ----------------------------------------------------------------------------
// Path: input beat to result beat via product, scale and update registers.
// Throughput: one beat per cycle unless out_tready stalls; the rate*dt and
//   reciprocal multiplies for the divide by 1000 each own a pipeline stage.
// Reset: rst_n low clears heading, speed and vertical speed to zero, loads
//   the configuration defaults and empties the pipeline.
// ----------------------------------------------------------------------------
module heading_speed_climb_slew_limiter_top import hscsl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // [0] intent_active, [16:1] elapsed_ms, [32:17] target_heading,
  // [49:33] target_speed, [65:50] target_altitude, [81:66] current_altitude
  input  logic [87:0] in_tdata,
  // [0] command
  input  logic [0:0]  in_tuser,
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] heading_out, [32:16] speed_out, [47:33] vertical_speed_out
  output logic [47:0] out_tdata,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  // configuration registers
  logic [15:0] heading_rate_r;
  logic [13:0] acceleration_r;
  logic [13:0] climb_rate_r;
  logic [16:0] max_speed_r;
  logic [14:0] max_altitude_r;
  logic [9:0]  alt_tolerance_r;

  // pipeline control
  logic        v1_r, v2_r, out_valid_r;
  logic        in_acc, en_out;
  pipe_en_t    pen;

  // input fields
  logic               in_active;
  logic [15:0]        in_ms;
  logic [15:0]        in_thdg;
  logic [16:0]        in_tspd;
  logic [15:0]        in_talt;
  logic signed [15:0] in_calt;

  // stage 1
  logic               s1_cmd_r, s1_upd_r;
  logic [15:0]        s1_thdg_r;
  logic [16:0]        s1_tspd_r;
  logic signed [17:0] s1_err_r;
  logic [15:0]        thdg_mod;
  logic [16:0]        tspd_clamp;
  logic [15:0]        talt_clamp;
  logic signed [17:0] err_nxt;

  // stage 2
  logic               s2_cmd_r, s2_upd_r;
  logic [15:0]        s2_thdg_r;
  logic [16:0]        s2_tspd_r;
  logic signed [14:0] s2_vs_r;
  logic [17:0]        err_mag;
  logic signed [24:0] cms;
  logic signed [24:0] climb_lim;
  logic signed [14:0] vs_nxt;

  // steps
  logic [STEP_W-1:0]  hdg_step, spd_step;

  // state, which is also the result register
  logic [15:0]        hdg_r, hdg_nxt;
  logic [16:0]        spd_r, spd_nxt;
  logic signed [14:0] vs_r, vs_st_nxt;

  // heading and speed update
  logic signed [16:0] hdiff_raw, hdiff_wrap, hdiff;
  logic [15:0]        hmag;
  logic signed [16:0] hturn;
  logic signed [17:0] hsum;
  logic [15:0]        hdg_upd;
  logic signed [17:0] sdiff;
  logic [16:0]        smag;
  logic [16:0]        spd_upd;

  // handshakes
  assign cfg_ready  = 1'b1;
  assign en_out     = v2_r && (!out_valid_r || out_tready);
  assign pen.s2     = v1_r && (!v2_r || en_out);
  assign in_tready  = !v1_r || pen.s2;
  assign in_acc     = in_tvalid && in_tready;
  assign pen.s1     = in_acc;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {vs_r, spd_r, hdg_r};

  // field unpacking
  assign in_active = in_tdata[0];
  assign in_ms     = in_tdata[16:1];
  assign in_thdg   = in_tdata[32:17];
  assign in_tspd   = in_tdata[49:33];
  assign in_talt   = in_tdata[65:50];
  assign in_calt   = $signed(in_tdata[81:66]);

  // configuration write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heading_rate_r  <= 16'd400;
      acceleration_r  <= 14'd1000;
      climb_rate_r    <= 14'd2000;
      max_speed_r     <= 17'd65000;
      max_altitude_r  <= 15'd12000;
      alt_tolerance_r <= 10'd50;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_HEADING_RATE:  heading_rate_r  <= cfg_data[15:0];
        CFG_ACCELERATION:  acceleration_r  <= cfg_data[13:0];
        CFG_CLIMB_RATE:    climb_rate_r    <= cfg_data[13:0];
        CFG_MAX_SPEED:     max_speed_r     <= cfg_data;
        CFG_MAX_ALTITUDE:  max_altitude_r  <= cfg_data[14:0];
        CFG_ALT_TOLERANCE: alt_tolerance_r <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) v1_r <= in_tvalid;
      if (!v2_r || en_out) v2_r <= v1_r;
      if (!out_valid_r || out_tready) out_valid_r <= v2_r;
    end
  end

  // stage 1: target wrap and clamps, altitude error
  always_comb begin
    thdg_mod   = (in_thdg >= FULL_TURN) ? in_thdg - FULL_TURN : in_thdg;
    tspd_clamp = (in_tspd > max_speed_r) ? max_speed_r : in_tspd;
    talt_clamp = (in_talt > {1'b0, max_altitude_r}) ? {1'b0, max_altitude_r} : in_talt;
    err_nxt    = $signed({2'b00, talt_clamp}) - $signed({{2{in_calt[15]}}, in_calt});
  end

  always_ff @(posedge clk) begin
    if (pen.s1) begin
      s1_cmd_r  <= (cmd_t'(in_tuser) == CMD_STOP);
      s1_upd_r  <= in_active && (in_ms != 16'd0);
      s1_thdg_r <= thdg_mod;
      s1_tspd_r <= tspd_clamp;
      s1_err_r  <= err_nxt;
    end
  end

  // step sizes for heading and speed
  hscsl_step_unit u_hdg_step (
    .clk  (clk),
    .en   (pen),
    .rate (heading_rate_r),
    .ms   (in_ms),
    .step (hdg_step)
  );

  hscsl_step_unit u_spd_step (
    .clk  (clk),
    .en   (pen),
    .rate ({2'b00, acceleration_r}),
    .ms   (in_ms),
    .step (spd_step)
  );

  // stage 2: vertical speed from altitude error, clamped to climb rate
  always_comb begin
    err_mag   = s1_err_r[17] ? 18'(-s1_err_r) : 18'(s1_err_r);
    cms       = $signed({{7{s1_err_r[17]}}, s1_err_r}) * 25'sd100;
    climb_lim = $signed({11'd0, climb_rate_r});
    if (err_mag <= {8'd0, alt_tolerance_r}) begin
      vs_nxt = '0;
    end else if (cms > climb_lim) begin
      vs_nxt = climb_lim[14:0];
    end else if (cms < -climb_lim) begin
      vs_nxt = 15'(-climb_lim);
    end else begin
      vs_nxt = cms[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (pen.s2) begin
      s2_cmd_r  <= s1_cmd_r;
      s2_upd_r  <= s1_upd_r;
      s2_thdg_r <= s1_thdg_r;
      s2_tspd_r <= s1_tspd_r;
      s2_vs_r   <= vs_nxt;
    end
  end

  // heading: shortest signed arc, limited turn, wrap into one turn
  always_comb begin
    hdiff_raw  = $signed({1'b0, s2_thdg_r}) - $signed({1'b0, hdg_r});
    hdiff_wrap = hdiff_raw[16] ? hdiff_raw + $signed({1'b0, FULL_TURN}) : hdiff_raw;
    hdiff      = (hdiff_wrap > $signed({1'b0, HALF_TURN}))
                 ? hdiff_wrap - $signed({1'b0, FULL_TURN}) : hdiff_wrap;
    hmag       = hdiff[16] ? 16'(-hdiff) : hdiff[15:0];
    if ({7'd0, hmag} <= hdg_step) begin
      hturn = hdiff;
    end else if (hdiff[16]) begin
      hturn = -$signed(hdg_step[16:0]);
    end else begin
      hturn = $signed(hdg_step[16:0]);
    end
    hsum = $signed({2'b00, hdg_r}) + $signed({hturn[16], hturn});
    if (hsum[17]) begin
      hdg_upd = 16'(hsum + $signed({2'b00, FULL_TURN}));
    end else if (hsum >= $signed({2'b00, FULL_TURN})) begin
      hdg_upd = 16'(hsum - $signed({2'b00, FULL_TURN}));
    end else begin
      hdg_upd = hsum[15:0];
    end
  end

  // speed: move toward clamped target by at most one step
  always_comb begin
    sdiff = $signed({1'b0, s2_tspd_r}) - $signed({1'b0, spd_r});
    smag  = sdiff[17] ? 17'(-sdiff) : sdiff[16:0];
    if ({6'd0, smag} <= spd_step) begin
      spd_upd = s2_tspd_r;
    end else if (sdiff[17]) begin
      spd_upd = spd_r - spd_step[16:0];
    end else begin
      spd_upd = spd_r + spd_step[16:0];
    end
  end

  // next state per item kind
  always_comb begin
    hdg_nxt   = hdg_r;
    spd_nxt   = spd_r;
    vs_st_nxt = vs_r;
    if (s2_cmd_r) begin
      spd_nxt   = '0;
      vs_st_nxt = '0;
    end else if (s2_upd_r) begin
      hdg_nxt   = hdg_upd;
      spd_nxt   = spd_upd;
      vs_st_nxt = s2_vs_r;
    end
  end

  // state update doubles as the result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdg_r <= '0;
      spd_r <= '0;
      vs_r  <= '0;
    end else if (en_out) begin
      hdg_r <= hdg_nxt;
      spd_r <= spd_nxt;
      vs_r  <= vs_st_nxt;
    end
  end

  // heading always stays inside one turn
  a_hdg_range: assert property (@(posedge clk) disable iff (!rst_n)
    hdg_r < FULL_TURN)
    else $error("heading left the 0 to 35999 range");

  // a stop beat leaves no motion behind
  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    en_out && s2_cmd_r |=> spd_r == 17'd0 && vs_r == 15'sd0)
    else $error("stop beat left speed or vertical speed non-zero");

  // an idle tick keeps the state
  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    en_out && !s2_cmd_r && !s2_upd_r |=>
      hdg_r == $past(hdg_r) && spd_r == $past(spd_r) && vs_r == $past(vs_r))
    else $error("inactive tick changed the state");

  // the input stage never blocks when empty
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !v1_r |-> in_tready)
    else $error("input stalled with an empty first stage");

endmodule
